// ===== rtl/esz_pkg.sv =====
// Shared types and constants of the expression sign and zero normalizer.
`default_nettype none

package esz_pkg;

  localparam int unsigned QDEPTH     = 4;
  localparam int unsigned QPTR_W     = $clog2(QDEPTH);
  localparam int unsigned QCNT_W     = $clog2(QDEPTH + 1);
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned OP_NUM     = 7;

  localparam logic [CHAR_W-1:0] ZERO_DIGIT_RST = 8'd48;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OP_CHARS     = 3'd0,
    CFG_ZERO_DIGIT   = 3'd1,
    CFG_DIGIT_MASK_0 = 3'd2,
    CFG_DIGIT_MASK_1 = 3'd3,
    CFG_DIGIT_MASK_2 = 3'd4,
    CFG_DIGIT_MASK_3 = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic              second;
    logic [CHAR_W-1:0] c0;
    logic [CHAR_W-1:0] c1;
    logic              empty;
    logic              last;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/expr_sign_zero_normalizer_top.sv =====
// Top level of the expression sign and zero normalizer.
// A result of an accepted character passes through a four-entry queue and the output register
// before it can transfer.
// Throughput: one input character per cycle while the queue is not full; the output moves
// one character per cycle when out_ready is high; a two-result character takes two transfers.
// Reset (rst_n low, synchronous): clears the queue, stream state and registers to reset values.
`default_nettype none

module expr_sign_zero_normalizer_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [esz_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [esz_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [esz_pkg::CHAR_W-1:0]      in_char,
  input  wire logic                            in_last,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [esz_pkg::CHAR_W-1:0]           out_char,
  output logic                                 out_empty,
  output logic                                 out_last
);

  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_valid;
  esz_pkg::entry_t q_entry;
  esz_pkg::entry_t q_head;

  esz_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_char   (in_char),
    .in_last   (in_last),
    .q_push    (q_push),
    .q_entry   (q_entry),
    .q_full    (q_full)
  );

  esz_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .valid      (q_valid),
    .head       (q_head)
  );

  esz_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .out_empty (out_empty),
    .out_last  (out_last)
  );

endmodule

`default_nettype wire

// ===== rtl/esz_front.sv =====
// Front end: configuration registers, character classification and collapse state.
`default_nettype none

module esz_front (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [esz_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [esz_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [esz_pkg::CHAR_W-1:0]           in_char,
  input  wire logic                                 in_last,
  output logic                                      q_push,
  output esz_pkg::entry_t                           q_entry,
  input  wire logic                                 q_full
);

  typedef struct packed {
    logic sign_run_active;
    logic minus_parity;
    logic zero_held;
    logic token_start;
    logic prev_digit_or_close;
  } state_t;

  typedef struct packed {
    logic [1:0]                  cnt;
    logic [esz_pkg::CHAR_W-1:0]  c0;
    logic [esz_pkg::CHAR_W-1:0]  c1;
  } emit_t;

  typedef struct packed {
    state_t st;
    emit_t  em;
  } work_t;

  localparam state_t STATE_RST = '{
    sign_run_active: 1'b0, minus_parity: 1'b0, zero_held: 1'b0,
    token_start: 1'b1, prev_digit_or_close: 1'b0
  };

  logic [esz_pkg::OP_NUM*esz_pkg::CHAR_W-1:0] op_chars_r;
  logic [esz_pkg::CHAR_W-1:0]                 zero_digit_r;
  logic [4*esz_pkg::CFG_DATA_W-1:0]           digit_mask_r;
  state_t                                     state_r;
  state_t                                     state_nxt;

  logic [esz_pkg::OP_NUM-1:0][esz_pkg::CHAR_W-1:0] op_b;
  logic        c_is_op;
  logic        c_is_digit;
  logic        plus_is_digit;
  logic        minus_is_digit;
  logic        c_is_minus;
  logic        c_is_sign;
  logic        accept;
  logic        empty;
  work_t       w;

  function automatic emit_t push_char(emit_t em, logic [esz_pkg::CHAR_W-1:0] x);
    emit_t r;
    r = em;
    if (em.cnt == 2'd0) begin
      r.c0  = x;
      r.cnt = 2'd1;
    end else if (em.cnt == 2'd1) begin
      r.c1  = x;
      r.cnt = 2'd2;
    end
    return r;
  endfunction

  function automatic work_t strip_feed(work_t w_in, logic [esz_pkg::CHAR_W-1:0] x,
                                       logic x_dig, logic x_op,
                                       logic [esz_pkg::CHAR_W-1:0] zc);
    work_t r;
    r = w_in;
    if (r.st.zero_held) begin
      r.st.zero_held = 1'b0;
      if (!x_dig) begin
        r.em = push_char(r.em, zc);
        r.st.token_start = 1'b0;
      end
    end
    if (x_op) begin
      r.em = push_char(r.em, x);
      r.st.token_start = 1'b1;
    end else if (r.st.token_start && (x == zc)) begin
      r.st.zero_held = 1'b1;
    end else begin
      r.em = push_char(r.em, x);
      r.st.token_start = 1'b0;
    end
    return r;
  endfunction

  function automatic work_t resolve_run(work_t w_in,
                                        logic [esz_pkg::CHAR_W-1:0] plus_c,
                                        logic [esz_pkg::CHAR_W-1:0] minus_c,
                                        logic [esz_pkg::CHAR_W-1:0] close_c,
                                        logic plus_dig, logic minus_dig,
                                        logic [esz_pkg::CHAR_W-1:0] zc);
    work_t                      r;
    logic [esz_pkg::CHAR_W-1:0] s;
    logic                       s_dig;
    logic                       go;
    r = w_in;
    r.st.sign_run_active = 1'b0;
    go    = r.st.prev_digit_or_close || r.st.minus_parity;
    s     = r.st.minus_parity ? minus_c : plus_c;
    s_dig = r.st.minus_parity ? minus_dig : plus_dig;
    if (go) begin
      r = strip_feed(r, s, s_dig, 1'b1, zc);
      r.st.prev_digit_or_close = s_dig || (s == close_c);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_chars_r   <= '0;
      zero_digit_r <= esz_pkg::ZERO_DIGIT_RST;
      digit_mask_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        esz_pkg::CFG_OP_CHARS: begin
          op_chars_r <= cfg_data[esz_pkg::OP_NUM*esz_pkg::CHAR_W-1:0];
        end
        esz_pkg::CFG_ZERO_DIGIT: begin
          zero_digit_r <= cfg_data[esz_pkg::CHAR_W-1:0];
        end
        esz_pkg::CFG_DIGIT_MASK_0: begin
          digit_mask_r[0*esz_pkg::CFG_DATA_W +: esz_pkg::CFG_DATA_W] <= cfg_data;
        end
        esz_pkg::CFG_DIGIT_MASK_1: begin
          digit_mask_r[1*esz_pkg::CFG_DATA_W +: esz_pkg::CFG_DATA_W] <= cfg_data;
        end
        esz_pkg::CFG_DIGIT_MASK_2: begin
          digit_mask_r[2*esz_pkg::CFG_DATA_W +: esz_pkg::CFG_DATA_W] <= cfg_data;
        end
        esz_pkg::CFG_DIGIT_MASK_3: begin
          digit_mask_r[3*esz_pkg::CFG_DATA_W +: esz_pkg::CFG_DATA_W] <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  assign op_b           = op_chars_r;
  assign c_is_digit     = digit_mask_r[in_char];
  assign plus_is_digit  = digit_mask_r[op_b[2]];
  assign minus_is_digit = digit_mask_r[op_b[3]];
  assign c_is_minus     = (in_char == op_b[3]);
  assign c_is_sign      = c_is_minus || (in_char == op_b[2]);

  always_comb begin
    c_is_op = 1'b0;
    for (int k = 0; k < esz_pkg::OP_NUM; k++) begin
      c_is_op = c_is_op || (op_b[k] == in_char);
    end
  end

  always_comb begin
    w.st  = state_r;
    w.em  = '0;
    empty = 1'b0;
    if (c_is_sign) begin
      if (!w.st.sign_run_active) begin
        if (w.st.zero_held) begin
          w.em = push_char(w.em, zero_digit_r);
          w.st.zero_held   = 1'b0;
          w.st.token_start = 1'b0;
        end
        w.st.sign_run_active = 1'b1;
        w.st.minus_parity    = c_is_minus;
      end else begin
        w.st.minus_parity = w.st.minus_parity ^ c_is_minus;
      end
    end else begin
      if (w.st.sign_run_active) begin
        w = resolve_run(w, op_b[2], op_b[3], op_b[1], plus_is_digit, minus_is_digit,
                        zero_digit_r);
      end
      w = strip_feed(w, in_char, c_is_digit, c_is_op, zero_digit_r);
      w.st.prev_digit_or_close = c_is_digit || (in_char == op_b[1]);
    end
    if (in_last) begin
      if (w.st.sign_run_active) begin
        w = resolve_run(w, op_b[2], op_b[3], op_b[1], plus_is_digit, minus_is_digit,
                        zero_digit_r);
      end
      if (w.st.zero_held) begin
        w.em = push_char(w.em, zero_digit_r);
        w.st.zero_held = 1'b0;
      end
      if (w.em.cnt == 2'd0) begin
        w.em  = push_char(w.em, '0);
        empty = 1'b1;
      end
      w.st = STATE_RST;
    end
  end

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign q_push    = accept && (w.em.cnt != 2'd0);
  assign state_nxt = accept ? w.st : state_r;

  always_comb begin
    q_entry.second = (w.em.cnt == 2'd2);
    q_entry.c0     = w.em.c0;
    q_entry.c1     = w.em.c1;
    q_entry.empty  = empty;
    q_entry.last   = in_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RST;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_run_no_zero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.sign_run_active |-> !state_r.zero_held)
    else $error("zero held during a sign run");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last) |=> (state_r.token_start && !state_r.sign_run_active &&
                             !state_r.zero_held && !state_r.prev_digit_or_close))
    else $error("state not cleared after final character");

  a_last_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last) |-> q_push)
    else $error("final character produced no result");

endmodule

`default_nettype wire

// ===== rtl/esz_queue.sv =====
// Result queue between the front end and the output serializer.
`default_nettype none

module esz_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire esz_pkg::entry_t push_entry,
  output logic                 full,
  input  wire logic            pop,
  output logic                 valid,
  output esz_pkg::entry_t      head
);

  esz_pkg::entry_t                   mem_r [esz_pkg::QDEPTH];
  logic [esz_pkg::QPTR_W-1:0]        wr_ptr_r;
  logic [esz_pkg::QPTR_W-1:0]        rd_ptr_r;
  logic [esz_pkg::QCNT_W-1:0]        count_r;
  logic [esz_pkg::QPTR_W-1:0]        wr_ptr_nxt;
  logic [esz_pkg::QPTR_W-1:0]        rd_ptr_nxt;
  logic [esz_pkg::QCNT_W-1:0]        count_nxt;

  localparam logic [esz_pkg::QPTR_W-1:0] PTR_LAST = esz_pkg::QPTR_W'(esz_pkg::QDEPTH - 1);
  localparam logic [esz_pkg::QCNT_W-1:0] CNT_FULL = esz_pkg::QCNT_W'(esz_pkg::QDEPTH);

  assign full  = (count_r == CNT_FULL);
  assign valid = (count_r != '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full) && !(pop && !valid))
    else $error("queue overflow or underflow");

endmodule

`default_nettype wire

// ===== rtl/esz_back.sv =====
// Output serializer: sends the one or two characters of each queued entry.
`default_nettype none

module esz_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_valid,
  input  wire esz_pkg::entry_t               q_head,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [esz_pkg::CHAR_W-1:0]         out_char,
  output logic                               out_empty,
  output logic                               out_last
);

  logic            cur_valid_r;
  esz_pkg::entry_t cur_r;
  logic            sub_r;
  logic            xfer;
  logic            final_beat;

  assign out_valid  = cur_valid_r;
  assign out_char   = sub_r ? cur_r.c1 : cur_r.c0;
  assign out_empty  = cur_r.empty && !sub_r;
  assign final_beat = sub_r || !cur_r.second;
  assign out_last   = cur_r.last && final_beat;
  assign xfer       = cur_valid_r && out_ready;
  assign q_pop      = q_valid && (!cur_valid_r || (xfer && final_beat));

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      sub_r       <= 1'b0;
    end else if (q_pop) begin
      cur_valid_r <= 1'b1;
      sub_r       <= 1'b0;
    end else if (xfer) begin
      cur_valid_r <= !final_beat;
      sub_r       <= !final_beat;
    end
  end

  a_second_beat: assert property (@(posedge clk) disable iff (!rst_n)
    sub_r |-> (cur_valid_r && cur_r.second && !cur_r.empty))
    else $error("second beat without a second character");

endmodule

`default_nettype wire

// ===== test/expr_sign_zero_normalizer_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the expression sign and zero normalizer top level.

module expr_sign_zero_normalizer_top_tb;
  import esz_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES  = 16;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned IDLE_PCT     = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_7 = 3'd7;

  localparam logic [63:0] DEC_OPS    = {8'h00, 8'h25, 8'h2F, 8'h2A, 8'h2D, 8'h2B, 8'h29, 8'h28};
  localparam logic [63:0] SAME_OPS   = {8'h00, 8'h25, 8'h2F, 8'h2A, 8'h2D, 8'h2D, 8'h29, 8'h28};
  localparam logic [63:0] DEC_MASK_0 = 64'h03FF_0000_0000_0000;
  localparam logic [63:0] HEX_MASK_1 = 64'h0000_007E_0000_0000;
  localparam logic [63:0] ALL_ONES   = {64{1'b1}};

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              empty;
    logic              last;
  } norm_char_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [CHAR_W-1:0]     in_char;
  logic                  in_last;
  logic                  out_valid;
  logic                  out_ready;
  logic [CHAR_W-1:0]     out_char;
  logic                  out_empty;
  logic                  out_last;

  logic [55:0]       op_chars_q;
  logic [CHAR_W-1:0] zero_q;
  logic [63:0]       dmask_q [4];
  bit                run_on;
  bit                parity;
  bit                zero_wait;
  bit                num_start;
  bit                after_operand;

  norm_char_t norm_chars_q [$];
  norm_char_t step_q [$];

  bit          idle_on;
  bit          hold_req;
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;

  expr_sign_zero_normalizer_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_char   (in_char),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .out_empty (out_empty),
    .out_last  (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [CHAR_W-1:0] op_byte(input int k);
    return op_chars_q[8*k +: 8];
  endfunction

  function automatic bit is_digit(input logic [CHAR_W-1:0] c);
    return dmask_q[c[7:6]][c[5:0]];
  endfunction

  function automatic bit is_op(input logic [CHAR_W-1:0] c);
    for (int k = 0; k < OP_NUM; k++) begin
      if (op_byte(k) == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void push_char(input logic [CHAR_W-1:0] c);
    if (step_q.size() < 2) step_q.push_back('{ch: c, empty: 1'b0, last: 1'b0});
  endfunction

  function automatic void strip_char(input logic [CHAR_W-1:0] c);
    if (zero_wait) begin
      zero_wait = 1'b0;
      if (!is_digit(c)) begin
        push_char(zero_q);
        num_start = 1'b0;
      end
    end
    if (is_op(c)) begin
      push_char(c);
      num_start = 1'b1;
    end else if (num_start && c == zero_q) begin
      zero_wait = 1'b1;
    end else begin
      push_char(c);
      num_start = 1'b0;
    end
  endfunction

  function automatic void note_operand(input logic [CHAR_W-1:0] c);
    after_operand = is_digit(c) || c == op_byte(1);
  endfunction

  function automatic void resolve_run();
    logic [CHAR_W-1:0] s;
    run_on = 1'b0;
    if (after_operand) s = parity ? op_byte(3) : op_byte(2);
    else if (parity) s = op_byte(3);
    else return;
    strip_char(s);
    note_operand(s);
  endfunction

  function automatic void clear_stream();
    run_on        = 1'b0;
    parity        = 1'b0;
    zero_wait     = 1'b0;
    num_start     = 1'b1;
    after_operand = 1'b0;
  endfunction

  function automatic void normalize_char(input logic [CHAR_W-1:0] c, input logic l);
    logic [CHAR_W-1:0] minus_c;
    bit                neg;
    step_q.delete();
    minus_c = op_byte(3);
    if (c == op_byte(2) || c == minus_c) begin
      neg = (c == minus_c);
      if (!run_on) begin
        if (zero_wait) begin
          push_char(zero_q);
          zero_wait = 1'b0;
          num_start = 1'b0;
        end
        run_on = 1'b1;
        parity = neg;
      end else begin
        parity ^= neg;
      end
    end else begin
      if (run_on) resolve_run();
      strip_char(c);
      note_operand(c);
    end
    if (l) begin
      if (run_on) resolve_run();
      if (zero_wait) begin
        push_char(zero_q);
        zero_wait = 1'b0;
      end
      if (step_q.size() == 0) step_q.push_back('{ch: '0, empty: 1'b1, last: 1'b0});
      step_q[step_q.size() - 1].last = 1'b1;
      clear_stream();
    end
    foreach (step_q[i]) norm_chars_q.push_back(step_q[i]);
  endfunction

  function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] d);
    case (idx)
      CFG_OP_CHARS:     op_chars_q = d[55:0];
      CFG_ZERO_DIGIT:   zero_q     = d[7:0];
      CFG_DIGIT_MASK_0: dmask_q[0] = d;
      CFG_DIGIT_MASK_1: dmask_q[1] = d;
      CFG_DIGIT_MASK_2: dmask_q[2] = d;
      CFG_DIGIT_MASK_3: dmask_q[3] = d;
      default: ;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] pick_char();
    int                r;
    logic [CHAR_W-1:0] c;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      for (int t = 0; t < 16; t++) begin
        c = 8'($urandom_range(0, 255));
        if (is_digit(c)) return c;
      end
      return zero_q;
    end
    if (r < 45) return zero_q;
    if (r < 70) return op_byte($urandom_range(2, 3));
    if (r < 88) return op_byte($urandom_range(0, OP_NUM - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_char(input logic [CHAR_W-1:0] c, input logic l);
    @(negedge clk);
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_char  <= c;
    in_last  <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    normalize_char(c, l);
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic send_exprs(input int n_items, input int noise_pct);
    int                sent;
    int                len;
    bit                noisy;
    logic [CHAR_W-1:0] c;
    sent = 0;
    while (sent < n_items) begin
      len   = $urandom_range(1, 12);
      noisy = ($urandom_range(0, 99) < noise_pct);
      for (int i = 0; i < len; i++) begin
        c = noisy ? 8'($urandom_range(0, 255)) : pick_char();
        send_char(c, i == len - 1);
      end
      sent += len;
    end
  endtask

  task automatic drain_all();
    @(negedge clk);
    in_valid <= 1'b0;
    while (norm_chars_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] d);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    apply_cfg(idx, d);
  endtask

  task automatic load_cfg(input logic [63:0] ops, input logic [63:0] zero,
                          input logic [63:0] m0, input logic [63:0] m1,
                          input logic [63:0] m2, input logic [63:0] m3);
    drain_all();
    write_reg(CFG_OP_CHARS, ops);
    write_reg(CFG_ZERO_DIGIT, zero);
    write_reg(CFG_DIGIT_MASK_0, m0);
    write_reg(CFG_DIGIT_MASK_1, m1);
    write_reg(CFG_DIGIT_MASK_2, m2);
    write_reg(CFG_DIGIT_MASK_3, m3);
  endtask

  task automatic test_reset_registers();
    send_exprs(30, 10);
  endtask

  task automatic test_directed_decimal();
    load_cfg(DEC_OPS, 64'h30, DEC_MASK_0, '0, '0, '0);
    idle_on = 1'b0;
    send_str("+");
    send_str("0");
    send_str("00-");
    send_str("3+-4");
    send_str("(--0)*7/0");
    send_str("%9");
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
    idle_on = 1'b1;
  endtask

  task automatic test_random_decimal();
    idle_on = 1'b0;
    send_exprs(100, 10);
    idle_on = 1'b1;
    send_exprs(200, 15);
  endtask

  task automatic test_output_holdoff();
    drain_all();
    idle_on  = 1'b0;
    hold_req = 1'b1;
    send_exprs(60, 0);
    idle_on = 1'b1;
  endtask

  task automatic test_sender_pause();
    send_exprs(30, 10);
    drain_all();
    send_exprs(30, 10);
  endtask

  task automatic test_register_sweep();
    load_cfg(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    send_exprs(40, 10);
    load_cfg('0, '0, '0, '0, '0, '0);
    send_exprs(40, 10);
    load_cfg(SAME_OPS, 64'h30, DEC_MASK_0, '0, '0, '0);
    send_exprs(40, 10);
    load_cfg(DEC_OPS, 64'h30, DEC_MASK_0 & ~(64'h1 << 48), '0, '0, '0);
    send_exprs(40, 10);
    load_cfg(DEC_OPS, 64'h2A, DEC_MASK_0, '0, '0, '0);
    send_exprs(40, 10);
    load_cfg(DEC_OPS, 64'h30, DEC_MASK_0, HEX_MASK_1, '0, '0);
    write_reg(CFG_IDX_SPARE_6, {$urandom, $urandom});
    write_reg(CFG_IDX_SPARE_7, {$urandom, $urandom});
    send_exprs(40, 10);
    repeat (2) begin
      load_cfg({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
               {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
      send_exprs(40, 20);
    end
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    norm_char_t exp_c;
    if (rst_n && out_valid && out_ready) begin
      if (norm_chars_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual char %h empty %b last %b",
                 $time, out_char, out_empty, out_last);
        mismatch_cnt++;
      end else begin
        exp_c = norm_chars_q.pop_front();
        if (out_char !== exp_c.ch) begin
          $display("%0t: out_char expected %h actual %h", $time, exp_c.ch, out_char);
          mismatch_cnt++;
        end
        if (out_empty !== exp_c.empty) begin
          $display("%0t: out_empty expected %b actual %b", $time, exp_c.empty, out_empty);
          mismatch_cnt++;
        end
        if (out_last !== exp_c.last) begin
          $display("%0t: out_last expected %b actual %b", $time, exp_c.last, out_last);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    in_char      = '0;
    in_last      = 1'b0;
    idle_on      = 1'b1;
    hold_req     = 1'b0;
    mismatch_cnt = 0;
    cycle_cnt    = 0;
    op_chars_q   = '0;
    zero_q       = ZERO_DIGIT_RST;
    foreach (dmask_q[i]) dmask_q[i] = '0;
    clear_stream();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_registers();
    test_directed_decimal();
    test_random_decimal();
    test_output_holdoff();
    test_sender_pause();
    test_register_sweep();

    drain_all();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && norm_chars_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
